FILE: sv/fys_pkg.sv
// ============================================================================
// fys_pkg
// Shared types and codes for the shuffle engine: request and result payloads,
// operation and status codes, and the request bundle of the shared divider.
// ============================================================================
`default_nettype none

package fys_pkg;

    // Width of the random word and of the divider datapath
    localparam int unsigned DIV_W = 32;

    // Operation codes carried in a request
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_RAND = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Result status codes
    localparam logic [2:0] STAT_LOADED   = 3'd0;
    localparam logic [2:0] STAT_STEP     = 3'd1;
    localparam logic [2:0] STAT_REJECT   = 3'd2;
    localparam logic [2:0] STAT_DONE     = 3'd3;
    localparam logic [2:0] STAT_DATA     = 3'd4;
    localparam logic [2:0] STAT_IGNORED  = 3'd5;
    localparam logic [2:0] STAT_OVERFLOW = 3'd6;

    // Request payload
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] elem_value;
        logic        is_last;
        logic [31:0] rand_word;
    } in_t;

    // Result payload
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_value;
        logic        out_last;
    } out_t;

    // Start bundle for the shared remainder unit
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

endpackage : fys_pkg

`default_nettype wire

FILE: sv/fys_ram.sv
// ============================================================================
// fys_ram
// Generic single-write, single-read memory with a registered read port.
// ============================================================================
`default_nettype none

module fys_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule : fys_ram

`default_nettype wire

FILE: sv/fys_div.sv
// ============================================================================
// fys_div
// Iterative restoring remainder unit: one quotient bit per cycle; done pulses
// for one cycle with the remainder held.
// ============================================================================
`default_nettype none

module fys_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire fys_pkg::div_req_t        req,
    output logic                          done,
    output logic [fys_pkg::DIV_W-1:0]     rem
);

    import fys_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [DIV_W-1:0] dvd_reg,  dvd_next;
    logic [DIV_W-1:0] dsr_reg,  dsr_next;
    logic [DIV_W-1:0] rem_reg,  rem_next;

    logic [DIV_W:0]   shifted;
    logic [DIV_W+1:0] diff;

    // Trial subtract of the divisor from the partial remainder
    assign shifted = {rem_reg, dvd_reg[DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W - 1);
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // Keep the difference when it did not go negative
            rem_next = diff[DIV_W+1] ? shifted[DIV_W-1:0] : diff[DIV_W-1:0];
            dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule : fys_div

`default_nettype wire

FILE: sv/fisher_yates_shuffle_engine_unit.sv
// ============================================================================
// fisher_yates_shuffle_engine_unit
// Fisher-Yates shuffle engine with rejection sampling of external random
// words, built around one shared iterative remainder unit and a store.
// ============================================================================
// Usage:
//   Requests enter on in_valid/in_ready with an in_t payload; every request
//   gives exactly one result on out_valid/out_ready with an out_t payload.
//   Load requests fill the store until one carries is_last; random-word
//   requests then run one shuffle attempt each; read requests drain the set.
// Processing, request accepted to result offered:
//   load or ignored request: result registered straight from the idle state.
//   read request: registered store read, then the result from S_RDOUT.
//   rejected random word: one remainder operation (the threshold).
//   accepted random word: two remainder operations on the shared divider,
//   then a store swap through S_RD_J, S_WR_I and S_WR_J.
// One request is in flight at a time; a new one is taken only when the
// sequencer is idle and the result register is empty or being drained.
// A stalled receiver holds the result register and blocks new requests.
// Reset empties the set and returns to the load phase; the store itself is
// not cleared, since only written entries are ever read.
// ============================================================================
`default_nettype none

module fisher_yates_shuffle_engine_unit #(
    parameter int unsigned DEPTH         = 1024,
    parameter int unsigned ELEMENT_WIDTH = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire fys_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output fys_pkg::out_t      out_data
);

    import fys_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned EW = ELEMENT_WIDTH;

    typedef enum logic [1:0] {
        PH_LOAD = 2'd0,
        PH_SHUF = 2'd1,
        PH_READ = 2'd2
    } phase_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_THR   = 7'b0000010,
        S_MOD   = 7'b0000100,
        S_RD_J  = 7'b0001000,
        S_WR_I  = 7'b0010000,
        S_WR_J  = 7'b0100000,
        S_RDOUT = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    sp_reg,    sp_next;
    logic [AW-1:0]    rp_reg,    rp_next;
    logic [AW-1:0]    j_reg,     j_next;
    logic [DIV_W-1:0] word_reg,  word_next;
    logic [EW-1:0]    di_reg,    di_next;
    logic             out_valid_reg, out_valid_next;
    out_t             out_data_reg,  out_data_next;

    logic             in_fire;
    logic             res_valid;
    out_t             res_data;
    logic [DIV_W-1:0] bound;
    logic             rp_last;
    logic [63:0]      rd_wide;

    div_req_t         div_req;
    logic             div_done;
    logic [DIV_W-1:0] div_rem;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [EW-1:0]    wr_data;
    logic [AW-1:0]    rd_addr;
    logic [EW-1:0]    rd_data;

    // Element store
    fys_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared remainder unit
    fys_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .rem   (div_rem)
    );

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;
    assign bound    = DIV_W'(sp_reg) + DIV_W'(1);
    assign rp_last  = (CW'(rp_reg) + CW'(1)) == count_reg;
    assign rd_wide  = 64'(rd_data);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        sp_next    = sp_reg;
        rp_next    = rp_reg;
        j_next     = j_reg;
        word_next  = word_reg;
        di_next    = di_reg;
        res_valid  = 1'b0;
        res_data   = '0;
        div_req    = '0;
        wr_en      = 1'b0;
        wr_addr    = count_reg[AW-1:0];
        wr_data    = EW'(in_data.elem_value);
        rd_addr    = rp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    res_valid       = 1'b1;
                    res_data.status = STAT_IGNORED;
                    priority if (phase_reg == PH_LOAD && in_data.op == OP_LOAD)
                    begin
                        if (count_reg < CW'(DEPTH))
                        begin
                            // Store the element and bump the count
                            wr_en           = 1'b1;
                            count_next      = count_reg + CW'(1);
                            res_data.status = STAT_LOADED;
                            if (in_data.is_last)
                            begin
                                if (count_reg == '0)
                                begin
                                    phase_next      = PH_READ;
                                    rp_next         = '0;
                                    res_data.status = STAT_DONE;
                                end
                                else
                                begin
                                    sp_next    = count_reg[AW-1:0];
                                    phase_next = PH_SHUF;
                                end
                            end
                        end
                        else
                        begin
                            // Drop the element; a full set still ends here
                            res_data.status = STAT_OVERFLOW;
                            if (in_data.is_last)
                            begin
                                sp_next    = AW'(DEPTH - 1);
                                phase_next = PH_SHUF;
                            end
                        end
                    end
                    else if (phase_reg == PH_SHUF && in_data.op == OP_RAND)
                    begin
                        // Compute the rejection threshold (2^32 - bound) mod bound
                        res_valid        = 1'b0;
                        word_next        = in_data.rand_word;
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(0) - bound;
                        div_req.divisor  = bound;
                        state_next       = S_THR;
                    end
                    else if (phase_reg == PH_READ && in_data.op == OP_READ)
                    begin
                        if (CW'(rp_reg) < count_reg)
                        begin
                            res_valid  = 1'b0;
                            state_next = S_RDOUT;
                        end
                        else
                        begin
                            count_next = '0;
                            sp_next    = '0;
                            rp_next    = '0;
                            phase_next = PH_LOAD;
                        end
                    end
                    else
                    begin
                        res_data.status = STAT_IGNORED;
                    end
                end
            end

            S_THR:
            begin
                if (div_done)
                begin
                    if (word_reg >= div_rem)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = word_reg;
                        div_req.divisor  = bound;
                        state_next       = S_MOD;
                    end
                    else
                    begin
                        res_valid       = 1'b1;
                        res_data.status = STAT_REJECT;
                        state_next      = S_IDLE;
                    end
                end
            end

            S_MOD:
            begin
                // Hold the read of entry i until j is known
                rd_addr = sp_reg;
                if (div_done)
                begin
                    j_next     = div_rem[AW-1:0];
                    state_next = S_RD_J;
                end
            end

            S_RD_J:
            begin
                rd_addr    = j_reg;
                di_next    = rd_data;
                state_next = S_WR_I;
            end

            S_WR_I:
            begin
                wr_en      = 1'b1;
                wr_addr    = sp_reg;
                wr_data    = rd_data;
                state_next = S_WR_J;
            end

            S_WR_J:
            begin
                // Finish the swap and move the top index down
                wr_en      = 1'b1;
                wr_addr    = j_reg;
                wr_data    = di_reg;
                sp_next    = sp_reg - AW'(1);
                res_valid  = 1'b1;
                state_next = S_IDLE;
                if (sp_reg == AW'(1))
                begin
                    phase_next      = PH_READ;
                    rp_next         = '0;
                    res_data.status = STAT_DONE;
                end
                else
                begin
                    res_data.status = STAT_STEP;
                end
            end

            S_RDOUT:
            begin
                res_valid          = 1'b1;
                res_data.status    = STAT_DATA;
                res_data.out_value = rd_wide[31:0];
                res_data.out_last  = rp_last;
                rp_next            = rp_reg + AW'(1);
                state_next         = S_IDLE;
                if (rp_last)
                begin
                    count_next = '0;
                    sp_next    = '0;
                    rp_next    = '0;
                    phase_next = PH_LOAD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register: load a new result, drop it once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_data;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_LOAD;
            count_reg     <= '0;
            sp_reg        <= '0;
            rp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            sp_reg        <= sp_next;
            rp_reg        <= rp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        j_reg        <= j_next;
        word_reg     <= word_next;
        di_reg       <= di_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule : fisher_yates_shuffle_engine_unit

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: shuffle engine testbench
// Drives load, random-word and read requests into the shuffle engine and
// compares every result against a cycle-free model of the store, kept in step
// with the accepted requests. Covers wrong-phase requests, one-element sets,
// rejected words, random sets, and finally a full store with overflow, under
// random idling on both handshakes.
// ----------------------------------------------------------------------------
module tb_top;
    import fys_pkg::*;

    localparam int STORE_DEPTH  = 1024;
    localparam int CALM_TAIL    = 150;    // last requests go with no idling
    localparam int STALL_LIMIT  = 4000;   // cycles with no handshake at all
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_REQS  = 150;
    localparam int FULL_STEPS   = 16;     // shuffle words after the full store
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef enum logic [1:0] {PH_LOADING, PH_SHUFFLING, PH_READING} set_phase_t;

    typedef struct {
        in_t req;
        bit  hold_for_drain;
    } pending_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    pending_req_t pending_reqs[$];
    out_t         expected_results[$];
    bit           req_taken = 1'b0;
    int           send_gap = 0;
    int           recv_gap = 0;
    int           quiet_cycles = 0;
    int           error_count = 0;
    int           random_reqs = 0;

    // Shadow of the engine state
    logic [31:0]  set_store [0:STORE_DEPTH-1];
    logic [10:0]  set_count = '0;
    logic [9:0]   top_index = '0;
    logic [9:0]   read_index = '0;
    set_phase_t   set_phase = PH_LOADING;

    fisher_yates_shuffle_engine_unit #(
        .DEPTH        (STORE_DEPTH),
        .ELEMENT_WIDTH(32)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------------
    function automatic void open_readout();
        read_index = '0;
        set_phase  = PH_READING;
    endfunction

    // End the set: small sets go straight to read-out
    function automatic logic [2:0] close_set();
        if (set_count < 11'd2)
        begin
            open_readout();
            return STAT_DONE;
        end
        top_index = 10'(set_count - 11'd1);
        set_phase = PH_SHUFFLING;
        return STAT_LOADED;
    endfunction

    function automatic out_t predict_shuffle_result(in_t req);
        out_t        res;
        logic [32:0] bound;
        logic [32:0] thr;
        logic [9:0]  pick;
        logic [31:0] held;
        logic        set_over;
        res        = '0;
        res.status = STAT_IGNORED;
        set_over   = 1'b0;
        if (set_phase == PH_LOADING && req.op == OP_LOAD)
        begin
            if (set_count < STORE_DEPTH)
            begin
                set_store[set_count[9:0]] = req.elem_value;
                set_count  = set_count + 11'd1;
                res.status = req.is_last ? close_set() : STAT_LOADED;
            end
            else
            begin
                // drop the element, but still honor the end of the set
                res.status = STAT_OVERFLOW;
                if (req.is_last)
                    void'(close_set());
            end
        end
        else if (set_phase == PH_SHUFFLING && req.op == OP_RAND)
        begin
            if ({1'b0, top_index} >= set_count || top_index == '0)
            begin
                open_readout();
                res.status = STAT_DONE;
            end
            else
            begin
                bound = {23'd0, top_index} + 33'd1;
                thr   = (33'h1_0000_0000 - bound) % bound;
                if ({1'b0, req.rand_word} >= thr)
                begin
                    pick = 10'({1'b0, req.rand_word} % bound);
                    held = set_store[top_index];
                    set_store[top_index] = set_store[pick];
                    set_store[pick] = held;
                    top_index = top_index - 10'd1;
                    if (top_index == '0)
                    begin
                        open_readout();
                        res.status = STAT_DONE;
                    end
                    else
                        res.status = STAT_STEP;
                end
                else
                    res.status = STAT_REJECT;
            end
        end
        else if (set_phase == PH_READING && req.op == OP_READ)
        begin
            if ({1'b0, read_index} < set_count)
            begin
                res.out_value = set_store[read_index];
                res.out_last  = ({1'b0, read_index} + 11'd1 == set_count);
                res.status    = STAT_DATA;
                read_index    = read_index + 10'd1;
                set_over      = res.out_last;
            end
            else
                set_over = 1'b1;
            // return to loading with an empty set
            if (set_over)
            begin
                set_count  = '0;
                top_index  = '0;
                read_index = '0;
                set_phase  = PH_LOADING;
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic flag_error(string msg);
        if (error_count < 200)
            $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_result(out_t got);
        out_t want;
        if (expected_results.size() == 0)
        begin
            flag_error($sformatf("result with nothing pending, status %0d", got.status));
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status)
            flag_error($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.out_value !== want.out_value)
            flag_error($sformatf("out_value %h, want %h", got.out_value, want.out_value));
        if (got.out_last !== want.out_last)
            flag_error($sformatf("out_last %0b, want %0b", got.out_last, want.out_last));
    endtask

    // Sample both handshakes, check results, advance the shadow model
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken = in_valid && in_ready;
            if (out_valid && out_ready)
                check_result(out_data);
            if (req_taken)
            begin
                expected_results.push_back(predict_shuffle_result(in_data));
                pending_reqs.delete(0);
            end
            if (req_taken || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || req_taken))
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_reqs.size() == 0)
                in_valid <= 1'b0;
            else if (pending_reqs[0].hold_for_drain && expected_results.size() != 0)
                in_valid <= 1'b0;
            else if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 9) == 0)
            begin
                in_valid <= 1'b0;
                send_gap = $urandom_range(0, 11);
            end
            else
            begin
                in_valid <= 1'b1;
                in_data  <= pending_reqs[0].req;
            end
        end
    end

    // Result side back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_gap > 0)
            begin
                out_ready <= 1'b0;
                recv_gap--;
            end
            else if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 11) == 0)
            begin
                out_ready <= 1'b0;
                recv_gap = $urandom_range(0, 11);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic queue_req(logic [1:0] op, logic [31:0] value, logic last,
                             logic [31:0] word, bit drain = 1'b0);
        pending_req_t p;
        p.req.op         = op;
        p.req.elem_value = value;
        p.req.is_last    = last;
        p.req.rand_word  = word;
        p.hold_for_drain = drain;
        pending_reqs.push_back(p);
    endtask

    // Request that the current phase ignores
    task automatic queue_stray(logic [1:0] right_op);
        logic [1:0] op;
        op = 2'($urandom_range(0, 3));
        if (op == right_op)
            op = OP_NONE;
        queue_req(op, $urandom(), 1'($urandom_range(0, 1)), $urandom());
    endtask

    // One whole set: load, shuffle, read out, with stray requests mixed in
    task automatic queue_set(int n, int ovf, bit drain_first);
        int          k;
        int          pos;
        logic [31:0] value;
        logic [31:0] word;
        logic [63:0] bound;
        logic [63:0] thr;
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_stray(OP_LOAD);
            value = $urandom();
            if ($urandom_range(0, 7) == 0)
                value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            queue_req(OP_LOAD, value, ovf == 0 && k == n - 1, $urandom(),
                      drain_first && k == 0);
        end
        for (k = 0; k < ovf; k++)
            queue_req(OP_LOAD, $urandom(), k == ovf - 1, $urandom());
        pos = n - 1;
        while (pos > 0)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_stray(OP_RAND);
            bound = 64'(pos + 1);
            thr   = ((64'd1 << 32) - bound) % bound;
            if (thr != 0 && $urandom_range(0, 3) == 0)
                word = $urandom_range(0, 32'(thr - 1));
            else
                word = $urandom();
            queue_req(OP_RAND, $urandom(), 1'($urandom_range(0, 1)), word);
            if (64'(word) >= thr)
                pos--;
            random_reqs++;
        end
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_stray(OP_READ);
            queue_req(OP_READ, $urandom(), 1'($urandom_range(0, 1)), $urandom());
        end
        random_reqs += 2 * n + ovf;
    endtask

    // Fill the store, overflow it with and without the end flag, then take
    // a few shuffle steps from the top of the full store
    task automatic queue_full_store();
        int k;
        for (k = 0; k < STORE_DEPTH; k++)
            queue_req(OP_LOAD, $urandom(), 1'b0, $urandom(), k == 0);
        queue_req(OP_LOAD, $urandom(), 1'b0, $urandom());
        queue_req(OP_LOAD, $urandom(), 1'b1, $urandom());
        for (k = 0; k < FULL_STEPS; k++)
            queue_req(OP_RAND, $urandom(), 1'($urandom_range(0, 1)), $urandom());
    endtask

    task automatic build_stimulus();
        int n;
        // wrong-phase requests on an empty engine
        queue_req(OP_READ, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        queue_req(OP_NONE, 32'h0, 1'b0, 32'h0);
        queue_req(OP_RAND, 32'h0, 1'b1, 32'hFFFF_FFFF);
        // one-element set finishes at once
        queue_req(OP_LOAD, 32'hFFFF_FFFF, 1'b1, 32'h0);
        queue_req(OP_LOAD, 32'h1234_5678, 1'b0, 32'h0);
        queue_req(OP_READ, 32'h0, 1'b0, 32'h0);
        // three elements: rejected word, threshold word, top word
        queue_req(OP_LOAD, 32'h0, 1'b0, 32'hFFFF_FFFF, 1'b1);
        queue_req(OP_LOAD, 32'hFFFF_FFFF, 1'b0, 32'h0);
        queue_req(OP_LOAD, 32'hA5A5_A5A5, 1'b1, 32'h0);
        queue_req(OP_READ, 32'h0, 1'b0, 32'h0);
        queue_req(OP_NONE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        queue_req(OP_RAND, 32'h0, 1'b0, 32'h0);
        queue_req(OP_RAND, 32'hFFFF_FFFF, 1'b1, 32'h1);
        queue_req(OP_LOAD, 32'h0, 1'b1, 32'h0);
        queue_req(OP_RAND, 32'h0, 1'b0, 32'hFFFF_FFFF);
        queue_req(OP_RAND, 32'h0, 1'b0, 32'h0);
        queue_req(OP_NONE, 32'h0, 1'b0, 32'h0);
        queue_req(OP_READ, 32'h0, 1'b1, 32'h0, 1'b1);
        queue_req(OP_READ, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);
        queue_req(OP_READ, 32'h0, 1'b0, 32'h0);
        // two-element set
        queue_req(OP_LOAD, 32'h0000_0001, 1'b0, 32'h0);
        queue_req(OP_LOAD, 32'h8000_0000, 1'b1, 32'h0);
        queue_req(OP_RAND, 32'h0, 1'b0, 32'h0);
        queue_req(OP_READ, 32'h0, 1'b0, 32'h0);
        queue_req(OP_READ, 32'h0, 1'b0, 32'h0);

        // random sets, mostly small
        random_reqs = 0;
        while (random_reqs < RANDOM_REQS)
        begin
            case ($urandom_range(0, 31))
                0:       n = $urandom_range(65, 300);
                1, 2, 3: n = $urandom_range(13, 64);
                default: n = $urandom_range(1, 12);
            endcase
            queue_set(n, 0, $urandom_range(0, 15) == 0);
        end

        // full store, then overflow with and without the end flag
        queue_full_store();
    endtask

    // ------------------------------------------------------------------------
    // Run control
    // ------------------------------------------------------------------------
    initial
    begin
        build_stimulus();
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
        while ((pending_reqs.size() != 0 || expected_results.size() != 0)
               && quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        if (quiet_cycles >= STALL_LIMIT)
            $display("DONE: errors detected");
        else
        begin
            repeat (DRAIN_CYCLES) @(posedge clk);
            if (error_count == 0)
                $display("DONE: 0 errors");
            else
                $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
